[rtl/core/one_wire_master_assert.svh]
// Assertion macros for the 1-Wire master RTL.
`ifndef ONE_WIRE_MASTER_ASSERT_SVH
`define ONE_WIRE_MASTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define OWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define OWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/owm_pkg.sv]
// Shared types, codes and constants of the 1-Wire bus master.
`default_nettype none

package owm_pkg;

  // Default number of bits in one transferred byte.
  localparam int BYTE_BITS_DEF = 8;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int DATA_W     = 8;
  localparam int LONG_W     = 10;
  localparam int SHORT_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LONG_W;

  // Register reset values.
  localparam logic [LONG_W-1:0]  RESET_LOW_DEF    = 10'd480;
  localparam logic [LONG_W-1:0]  PRESENCE_DEF     = 10'd80;
  localparam logic [LONG_W-1:0]  RESET_TAIL_DEF   = 10'd400;
  localparam logic [SHORT_W-1:0] WRITE_ONE_DEF    = 7'd5;
  localparam logic [SHORT_W-1:0] WRITE_ZERO_DEF   = 7'd60;
  localparam logic [SHORT_W-1:0] READ_LOW_DEF     = 7'd1;
  localparam logic [SHORT_W-1:0] READ_SAMPLE_DEF  = 7'd14;
  localparam logic [SHORT_W-1:0] SLOT_LENGTH_DEF  = 7'd60;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_RESET_TAIL  = 3'd2,
    REG_WRITE_ONE   = 3'd3,
    REG_WRITE_ZERO  = 3'd4,
    REG_READ_LOW    = 3'd5,
    REG_READ_SAMPLE = 3'd6,
    REG_SLOT_LENGTH = 3'd7
  } reg_idx_e;

  // Bus sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_WRITE,
    PH_READ
  } phase_e;

  // Timing configuration seen by the sequencer.
  typedef struct packed {
    logic [LONG_W-1:0]  reset_low_time;
    logic [LONG_W-1:0]  presence_wait;
    logic [LONG_W-1:0]  reset_tail_time;
    logic [SHORT_W-1:0] write_one_low;
    logic [SHORT_W-1:0] write_zero_low;
    logic [SHORT_W-1:0] read_low;
    logic [SHORT_W-1:0] read_sample_delay;
    logic [SHORT_W-1:0] slot_length;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] tx_byte;
    logic              line_in;
  } item_t;

  // One result item.
  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic [DATA_W-1:0] rx_byte;
    logic              presence;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/owm_if.sv]
// Valid/ready channel interfaces for the command and result streams.
`default_nettype none

interface owm_cmd_if;
  import owm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] tx_byte;
  logic              line_in;

  modport source (output valid, output cmd, output tx_byte, output line_in, input ready);
  modport sink   (input valid, input cmd, input tx_byte, input line_in, output ready);
endinterface

interface owm_res_if;
  import owm_pkg::*;
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic [DATA_W-1:0] rx_byte;
  logic              presence;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output rx_byte, output presence, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input rx_byte, input presence, output ready);
endinterface

`default_nettype wire

[rtl/core/owm_cfg.sv]
// Configuration register file of the 1-Wire master.
`default_nettype none

module owm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output owm_pkg::cfg_t                  cfg
);
  import owm_pkg::*;

  // Register writes decode the index; every index has a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time    <= RESET_LOW_DEF;
      cfg.presence_wait     <= PRESENCE_DEF;
      cfg.reset_tail_time   <= RESET_TAIL_DEF;
      cfg.write_one_low     <= WRITE_ONE_DEF;
      cfg.write_zero_low    <= WRITE_ZERO_DEF;
      cfg.read_low          <= READ_LOW_DEF;
      cfg.read_sample_delay <= READ_SAMPLE_DEF;
      cfg.slot_length       <= SLOT_LENGTH_DEF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:   cfg.reset_low_time    <= cfg_wdata[LONG_W-1:0];
        REG_PRES_WAIT:   cfg.presence_wait     <= cfg_wdata[LONG_W-1:0];
        REG_RESET_TAIL:  cfg.reset_tail_time   <= cfg_wdata[LONG_W-1:0];
        REG_WRITE_ONE:   cfg.write_one_low     <= cfg_wdata[SHORT_W-1:0];
        REG_WRITE_ZERO:  cfg.write_zero_low    <= cfg_wdata[SHORT_W-1:0];
        REG_READ_LOW:    cfg.read_low          <= cfg_wdata[SHORT_W-1:0];
        REG_READ_SAMPLE: cfg.read_sample_delay <= cfg_wdata[SHORT_W-1:0];
        REG_SLOT_LENGTH: cfg.slot_length       <= cfg_wdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/owm_engine.sv]
// Bus sequencer: state registers and the one-tick step logic.
`default_nettype none

module owm_engine #(
  parameter int BYTE_BITS = owm_pkg::BYTE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  owm_pkg::item_t item,
  input  owm_pkg::cfg_t  cfg,
  output owm_pkg::res_t  res
);
  import owm_pkg::*;

  localparam int BI_W = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;
  localparam logic [BI_W-1:0] LAST_BIT = BI_W'(BYTE_BITS - 1);

  // Sequencer state.
  phase_e               phase;
  logic [LONG_W-1:0]    tick_count;
  logic [BI_W-1:0]      bit_index;
  logic [BYTE_BITS-1:0] shift_reg;
  logic                 presence_flag;
  logic [DATA_W-1:0]    rx_latch;

  // Next values.
  phase_e               phase_next;
  logic [LONG_W-1:0]    tick_count_next;
  logic [BI_W-1:0]      bit_index_next;
  logic [BYTE_BITS-1:0] shift_reg_next;
  logic                 presence_flag_next;
  logic [DATA_W-1:0]    rx_latch_next;
  logic                 drive;
  logic                 done;

  logic [BYTE_BITS-1:0] tx_ext;
  logic [DATA_W-1:0]    sr_low;
  logic [LONG_W-1:0]    tc_inc;
  logic [LONG_W-1:0]    rst_low_len;
  logic [LONG_W-1:0]    pres_len;
  logic [LONG_W-1:0]    tail_len;
  logic [SHORT_W-1:0]   slot_len;
  logic [SHORT_W-1:0]   slot_last;
  logic [SHORT_W:0]     sample_sum;
  logic [SHORT_W-1:0]   sample_at;
  logic [SHORT_W-1:0]   write_low;

  // Fit the transmit byte into the shift register, and the shift register into a byte.
  for (genvar g = 0; g < BYTE_BITS; g++) begin : g_tx
    if (g < DATA_W) begin : g_bit
      assign tx_ext[g] = item.tx_byte[g];
    end else begin : g_pad
      assign tx_ext[g] = 1'b0;
    end
  end

  for (genvar g = 0; g < DATA_W; g++) begin : g_rx
    if (g < BYTE_BITS) begin : g_bit
      assign sr_low[g] = shift_reg[g];
    end else begin : g_pad
      assign sr_low[g] = 1'b0;
    end
  end

  // Segment lengths; a zero length counts as one tick.
  always_comb begin
    rst_low_len = (cfg.reset_low_time  == '0) ? LONG_W'(1) : cfg.reset_low_time;
    pres_len    = (cfg.presence_wait   == '0) ? LONG_W'(1) : cfg.presence_wait;
    tail_len    = (cfg.reset_tail_time == '0) ? LONG_W'(1) : cfg.reset_tail_time;
    slot_len    = (cfg.slot_length     == '0) ? SHORT_W'(1) : cfg.slot_length;
    slot_last   = slot_len - SHORT_W'(1);
    sample_sum  = {1'b0, cfg.read_low} + {1'b0, cfg.read_sample_delay};
    sample_at   = (sample_sum > {1'b0, slot_last}) ? slot_last : sample_sum[SHORT_W-1:0];
  end

  // One microsecond of bus activity.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    presence_flag_next = presence_flag;
    rx_latch_next      = rx_latch;
    drive              = 1'b0;
    done               = 1'b0;
    write_low          = '0;

    // A command starts on the tick it arrives, but only when idle.
    if (phase == PH_IDLE && item.cmd != CMD_NONE) begin
      tick_count_next = '0;
      bit_index_next  = '0;
      case (item.cmd)
        CMD_RESET: phase_next = PH_RST_LOW;
        CMD_WRITE: begin
          phase_next     = PH_WRITE;
          shift_reg_next = tx_ext;
        end
        CMD_READ: begin
          phase_next     = PH_READ;
          shift_reg_next = '0;
        end
        default: ;
      endcase
    end

    tc_inc = tick_count_next + LONG_W'(1);

    unique case (phase_next)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive           = 1'b1;
        tick_count_next = tc_inc;
        if (tc_inc >= rst_low_len) begin
          phase_next      = PH_RST_WAIT;
          tick_count_next = '0;
        end
      end
      PH_RST_WAIT: begin
        tick_count_next = tc_inc;
        if (tc_inc >= pres_len) begin
          phase_next      = PH_RST_TAIL;
          tick_count_next = '0;
        end
      end
      PH_RST_TAIL: begin
        // A device answers by holding the line low.
        if (tick_count_next == '0) begin
          presence_flag_next = ~item.line_in;
        end
        tick_count_next = tc_inc;
        if (tc_inc >= tail_len) begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end
      end
      PH_WRITE: begin
        if (tick_count_next < {3'b0, slot_len}) begin
          write_low       = shift_reg_next[0] ? cfg.write_one_low : cfg.write_zero_low;
          drive           = tick_count_next < {3'b0, write_low};
          tick_count_next = tc_inc;
        end else begin
          // Recovery tick: move to the next bit or finish.
          shift_reg_next  = shift_reg_next >> 1;
          tick_count_next = '0;
          if (bit_index_next == LAST_BIT) begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
            done           = 1'b1;
          end else begin
            bit_index_next = bit_index_next + BI_W'(1);
          end
        end
      end
      PH_READ: begin
        if (tick_count_next < {3'b0, slot_len}) begin
          drive = tick_count_next < {3'b0, cfg.read_low};
          if (tick_count_next == {3'b0, sample_at}) begin
            shift_reg_next                = shift_reg_next >> 1;
            shift_reg_next[BYTE_BITS-1]   = item.line_in;
          end
          tick_count_next = tc_inc;
        end else begin
          tick_count_next = '0;
          if (bit_index_next == LAST_BIT) begin
            phase_next     = PH_IDLE;
            bit_index_next = '0;
            done           = 1'b1;
            rx_latch_next  = sr_low;
          end else begin
            bit_index_next = bit_index_next + BI_W'(1);
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  // Result of this tick.
  always_comb begin
    res.drive_low = drive;
    res.busy_res  = (phase_next != PH_IDLE) || done;
    res.done_res  = done;
    res.rx_byte   = rx_latch_next;
    res.presence  = presence_flag_next;
  end

  // State moves on with each item that passes through.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_reg     <= '0;
      presence_flag <= 1'b0;
      rx_latch      <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      presence_flag <= presence_flag_next;
      rx_latch      <= rx_latch_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/one_wire_master.sv]
// Top level of the 1-Wire bus master: input register, sequencer and result register.
//
// Each command transfer is one microsecond of bus time and produces exactly one result
// transfer. With the result side ready, a command transfer is taken in every clock cycle
// and its result is offered after it has passed the input register and the result register.
// The sequencer step is a single pass of logic from the input register into the result
// register. While a result waits to be taken, the input register holds one more command and
// the input then stalls until the result leaves. A command is started only from idle;
// commands during a reset, write or read are ignored. Timing registers may be written only
// while the block is idle and both stages are empty.
`default_nettype none

module one_wire_master #(
  parameter int BYTE_BITS = owm_pkg::BYTE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  owm_cmd_if.sink                        cmd_ch,
  owm_res_if.source                      res_ch,
  input  logic                           cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import owm_pkg::*;

  `include "one_wire_master_assert.svh"

  cfg_t  cfg;
  item_t item_q;
  logic  item_valid;
  res_t  res_next;
  res_t  res_q;
  logic  res_valid;
  logic  advance;

  // The input stage moves on when the result register is free or being read.
  assign advance      = item_valid && (!res_valid || res_ch.ready);
  assign cmd_ch.ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      item_valid <= cmd_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.ready && cmd_ch.valid) begin
      item_q.cmd     <= cmd_ch.cmd;
      item_q.tx_byte <= cmd_ch.tx_byte;
      item_q.line_in <= cmd_ch.line_in;
    end
  end

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owm_engine #(
    .BYTE_BITS (BYTE_BITS)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_q),
    .cfg     (cfg),
    .res     (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  assign res_ch.valid     = res_valid;
  assign res_ch.drive_low = res_q.drive_low;
  assign res_ch.busy_res  = res_q.busy_res;
  assign res_ch.done_res  = res_q.done_res;
  assign res_ch.rx_byte   = res_q.rx_byte;
  assign res_ch.presence  = res_q.presence;

  // Checks on the pipeline and the result contents.
  `OWM_ASSERT(a_advance_fills, advance |=> res_valid, "result register not filled")
  `OWM_ASSERT(a_no_overwrite, res_valid && !res_ch.ready |-> !advance, "result overwritten")
  `OWM_ASSERT(a_drive_busy, res_valid && (res_q.drive_low || res_q.done_res) |-> res_q.busy_res,
    "bus activity reported while not busy")
  `OWM_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid && !item_valid,
    "pipeline not empty after reset")

endmodule

`default_nettype wire
